// File: hdl/pasq_pkg.sv
// Package for the priority/age sorted queue.
// Holds transaction payload types, opcode and status codes. No dependencies.
`timescale 1ns / 1ps

package pasq_pkg;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_SERVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Fixed field widths of the transaction payloads
  localparam int unsigned ID_FIELD_W  = 16;
  localparam int unsigned AGE_FIELD_W = 7;
  localparam int unsigned LVL_W       = 2;
  localparam int unsigned OCC_W       = 5;

  typedef struct packed {
    logic                   opcode;
    logic [ID_FIELD_W-1:0]  patient_id;
    logic [LVL_W-1:0]       level;
    logic [AGE_FIELD_W-1:0] age;
  } pasq_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [ID_FIELD_W-1:0]  served_id;
    logic [LVL_W-1:0]       served_level;
    logic [AGE_FIELD_W-1:0] served_age;
    logic [OCC_W-1:0]       occupancy;
  } pasq_out_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // shift right behind the insertion point, load new entry
    logic srv;   // shift every entry one place toward the head
  } pasq_cell_ctrl_t;

endpackage

// File: hdl/pasq_cell.sv
// One slot of the sorted queue chain: holds an entry, compares it with the
// incoming key and takes data from its left or right neighbor. Uses pasq_pkg.
`timescale 1ns / 1ps

module pasq_cell #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned AGE_W = 7
) (
  input  logic                           clk_i,
  input  pasq_pkg::pasq_cell_ctrl_t      ctrl_i,
  input  logic                           occ_i,
  input  logic [ID_W-1:0]                new_id_i,
  input  logic [pasq_pkg::LVL_W-1:0]     new_lvl_i,
  input  logic [AGE_W-1:0]               new_age_i,
  input  logic                           left_ahead_i,
  input  logic [ID_W-1:0]                left_id_i,
  input  logic [pasq_pkg::LVL_W-1:0]     left_lvl_i,
  input  logic [AGE_W-1:0]               left_age_i,
  input  logic [ID_W-1:0]                right_id_i,
  input  logic [pasq_pkg::LVL_W-1:0]     right_lvl_i,
  input  logic [AGE_W-1:0]               right_age_i,
  output logic                           ahead_o,
  output logic [ID_W-1:0]                id_o,
  output logic [pasq_pkg::LVL_W-1:0]     lvl_o,
  output logic [AGE_W-1:0]               age_o
);
  import pasq_pkg::*;

  logic [ID_W-1:0]  id_q, id_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [AGE_W-1:0] age_q, age_d;

  // Stored entry keeps its place ahead of the new key
  assign ahead_o = occ_i && ((lvl_q > new_lvl_i) ||
                             ((lvl_q == new_lvl_i) && (age_q >= new_age_i)));

  always_comb begin
    id_d  = id_q;
    lvl_d = lvl_q;
    age_d = age_q;
    if (ctrl_i.ins && !ahead_o) begin
      if (left_ahead_i) begin
        // insertion point: load the new entry
        id_d  = new_id_i;
        lvl_d = new_lvl_i;
        age_d = new_age_i;
      end else begin
        // behind the insertion point: advance one place toward the tail
        id_d  = left_id_i;
        lvl_d = left_lvl_i;
        age_d = left_age_i;
      end
    end else if (ctrl_i.srv) begin
      id_d  = right_id_i;
      lvl_d = right_lvl_i;
      age_d = right_age_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    lvl_q <= lvl_d;
    age_q <= age_d;
  end

  assign id_o  = id_q;
  assign lvl_o = lvl_q;
  assign age_o = age_q;

endmodule

// File: hdl/priority_age_sorted_queue_unit.sv
// Top level of the priority/age sorted queue: a chain of pasq_cell slots,
// the entry counter and the result register. Uses pasq_pkg and pasq_cell.
`timescale 1ns / 1ps

// The queue is a row of CAPACITY identical cells kept sorted from the head
// (cell 0): higher level first, and within a level greater age first, with
// equal keys in arrival order. Every cell compares its own entry with the
// incoming key in parallel, so an insert or a serve updates all cells at
// once: the cells behind the insertion point shift one place toward the
// tail, or on a serve every cell takes its right neighbor's entry. One
// transaction is accepted per cycle while the input is ready, which it is
// whenever the output register is empty or is being drained in the same
// cycle; its result appears in the output register on the next cycle. So a
// stalled consumer stalls the input after one result. Inserting into a
// full queue returns the full status and changes nothing; serving an empty
// queue returns the empty status. Reset clears only the entry counter and
// valid flag; cells past the count are never read, so need no clearing.
module priority_age_sorted_queue_unit #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AGE_BITS = 7,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pasq_pkg::pasq_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pasq_pkg::pasq_out_t  out_data_o
);
  import pasq_pkg::*;

  // Stored widths: the field width, narrowed further by the parameters
  localparam int unsigned ID_W  = (ID_BITS  < ID_FIELD_W)  ? ID_BITS  : ID_FIELD_W;
  localparam int unsigned AGE_W = (AGE_BITS < AGE_FIELD_W) ? AGE_BITS : AGE_FIELD_W;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             fire;
  logic             full, empty;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_vld_q;
  pasq_out_t        out_data_q, out_data_d;
  pasq_cell_ctrl_t  ctrl;

  logic [ID_W-1:0]  new_id;
  logic [AGE_W-1:0] new_age;

  logic             ahead_w [CAPACITY];
  logic [ID_W-1:0]  id_w    [CAPACITY];
  logic [LVL_W-1:0] lvl_w   [CAPACITY];
  logic [AGE_W-1:0] age_w   [CAPACITY];

  // Accept while the result register is free or emptying this cycle
  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  assign new_id  = in_data_i.patient_id[ID_W-1:0];
  assign new_age = in_data_i.age[AGE_W-1:0];

  // Drop inserts into a full queue and serves of an empty one
  assign ctrl.ins = fire && (in_data_i.opcode == OP_INSERT) && !full;
  assign ctrl.srv = fire && (in_data_i.opcode == OP_SERVE)  && !empty;

  // Chain of slots; cell 0 is the head
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             occ;
    logic             l_ahead;
    logic [ID_W-1:0]  l_id, r_id;
    logic [LVL_W-1:0] l_lvl, r_lvl;
    logic [AGE_W-1:0] l_age, r_age;

    assign occ = (CNT_W'(g) < count_q);

    if (g == 0) begin : g_head
      assign l_ahead = 1'b1;
      assign l_id    = new_id;
      assign l_lvl   = in_data_i.level;
      assign l_age   = new_age;
    end else begin : g_body
      assign l_ahead = ahead_w[g-1];
      assign l_id    = id_w[g-1];
      assign l_lvl   = lvl_w[g-1];
      assign l_age   = age_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      // The tail slot is past the count after a serve; keep its contents
      assign r_id  = id_w[g];
      assign r_lvl = lvl_w[g];
      assign r_age = age_w[g];
    end else begin : g_mid
      assign r_id  = id_w[g+1];
      assign r_lvl = lvl_w[g+1];
      assign r_age = age_w[g+1];
    end

    pasq_cell #(
      .ID_W  (ID_W),
      .AGE_W (AGE_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .new_id_i     (new_id),
      .new_lvl_i    (in_data_i.level),
      .new_age_i    (new_age),
      .left_ahead_i (l_ahead),
      .left_id_i    (l_id),
      .left_lvl_i   (l_lvl),
      .left_age_i   (l_age),
      .right_id_i   (r_id),
      .right_lvl_i  (r_lvl),
      .right_age_i  (r_age),
      .ahead_o      (ahead_w[g]),
      .id_o         (id_w[g]),
      .lvl_o        (lvl_w[g]),
      .age_o        (age_w[g])
    );
  end

  // Entry counter
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.srv) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result of the transaction accepted this cycle
  always_comb begin
    out_data_d              = '0;
    out_data_d.occupancy    = OCC_W'(count_d);
    if (in_data_i.opcode == OP_INSERT) begin
      out_data_d.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      out_data_d.status = ST_EMPTY;
    end else begin
      out_data_d.status       = ST_SERVED;
      out_data_d.served_id    = ID_FIELD_W'(id_w[0]);
      out_data_d.served_level = lvl_w[0];
      out_data_d.served_age   = AGE_FIELD_W'(age_w[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until a new transaction replaces it
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/pasq_checker.sv
// Port-level checks for priority_age_sorted_queue_unit and the bind that
// attaches them. Uses pasq_pkg.
`timescale 1ns / 1ps

module pasq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pasq_pkg::pasq_out_t out_data_o
);
  import pasq_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Every accepted transaction yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("missing result after accepted transaction");

  // Only a serve carries served fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_SERVED) |->
      (out_data_o.served_id == '0) && (out_data_o.served_level == '0) &&
      (out_data_o.served_age == '0))
    else $error("served fields set on a non-serve result");

  // Empty reports no entries; full reports a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |-> (out_data_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      (out_data_o.occupancy == OCC_W'(CAPACITY)))
    else $error("full status without a full queue");

endmodule

bind priority_age_sorted_queue_unit pasq_checker #(
  .CAPACITY (CAPACITY)
) u_pasq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
